FILE: design/lsre_pkg.sv
// ----------------------------------------------------------------------------
// lsre_pkg
// Shared types and constants of the link-state route engine.
// ----------------------------------------------------------------------------
package lsre_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = 4;
  localparam int MODE_W    = 2;
  localparam int LINK_W    = 16;
  localparam int COST_W    = 20;
  localparam int CFG_W     = 5;
  localparam int HOP_LIMIT = 16;
  localparam int HOP_W     = $clog2(HOP_LIMIT);

  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
  localparam logic [COST_W-1:0] COST_MAX  = 20'hFFFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET  = 2'd0,
    MODE_REC  = 2'd1,
    MODE_QRY  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef struct packed {
    logic cap;
    logic link_wr_a;
    logic link_wr_b;
    logic rec_clr;
    logic src_start;
    logic seed_rd;
    logic scan;
    logic commit;
    logic relax_rd;
    logic wb;
    logic rec_emit;
    logic q_start;
    logic q_one;
    logic q_rd;
    logic q_emit;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  set_ok;
    logic  q_one;
    logic  q_last;
    logic  best_ok;
    logic  out_free;
  } sts_t;

endpackage

FILE: design/lsre_in_if.sv
// ----------------------------------------------------------------------------
// lsre_in_if
// Command channel: set link, recompute, route query.
// ----------------------------------------------------------------------------
interface lsre_in_if;
  logic                          valid;
  logic                          ready;
  logic [lsre_pkg::MODE_W-1:0]   mode;
  logic [lsre_pkg::NODE_W-1:0]   node_a;
  logic [lsre_pkg::NODE_W-1:0]   node_b;
  logic [lsre_pkg::LINK_W-1:0]   link_cost;
  logic                          link_down;

  modport source (output valid, mode, node_a, node_b, link_cost, link_down, input ready);
  modport sink   (input valid, mode, node_a, node_b, link_cost, link_down, output ready);
endinterface

FILE: design/lsre_out_if.sv
// ----------------------------------------------------------------------------
// lsre_out_if
// Result channel: recompute done and route query hops.
// ----------------------------------------------------------------------------
interface lsre_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic                          reachable;
  logic [lsre_pkg::COST_W-1:0]   path_cost;
  logic                          has_hop;
  logic [lsre_pkg::NODE_W-1:0]   hop_node;
  logic                          last;

  modport source (output valid, kind, reachable, path_cost, has_hop, hop_node, last,
                  input ready);
  modport sink   (input valid, kind, reachable, path_cost, has_hop, hop_node, last,
                  output ready);
endinterface

FILE: design/lsre_ram.sv
// ----------------------------------------------------------------------------
// lsre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lsre_ctrl.sv
// ----------------------------------------------------------------------------
// lsre_ctrl
// Sequencer: decodes items, walks sources, scans, relaxes and query hops.
// ----------------------------------------------------------------------------
module lsre_ctrl #(
  parameter int MAX_NODES = lsre_pkg::MAX_NODES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  lsre_pkg::sts_t                     sts,
  input  logic [$clog2(MAX_NODES+1)-1:0]     n,
  output lsre_pkg::cmd_t                     cmd,
  output logic [$clog2(MAX_NODES)-1:0]       k,
  output logic [$clog2(MAX_NODES)-1:0]       s
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_DECODE  = 16'h0002,
    ST_SET_A   = 16'h0004,
    ST_SET_B   = 16'h0008,
    ST_REC_CLR = 16'h0010,
    ST_SEED    = 16'h0020,
    ST_SEED_T  = 16'h0040,
    ST_SCAN    = 16'h0080,
    ST_PICK    = 16'h0100,
    ST_RELAX   = 16'h0200,
    ST_RELAX_T = 16'h0400,
    ST_WB      = 16'h0800,
    ST_REC_OUT = 16'h1000,
    ST_Q_CHECK = 16'h2000,
    ST_Q_RD    = 16'h4000,
    ST_Q_EMIT  = 16'h8000
  } state_t;

  state_t        state_r, state_nxt;
  logic [NW-1:0] k_r, k_nxt;
  logic [NW-1:0] s_r, s_nxt;
  logic [NW-1:0] it_r, it_nxt;
  logic          k_last, s_last, it_last;

  assign k_last  = (CW'(k_r) + CW'(1)) == n;
  assign s_last  = (CW'(s_r) + CW'(1)) == n;
  assign it_last = (CW'(it_r) + CW'(1)) == n;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    s_nxt     = s_r;
    it_nxt    = it_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.mode)
          lsre_pkg::MODE_SET: state_nxt = sts.set_ok ? ST_SET_A : ST_IDLE;
          lsre_pkg::MODE_REC: state_nxt = ST_REC_CLR;
          lsre_pkg::MODE_QRY: state_nxt = ST_Q_CHECK;
          default:            state_nxt = ST_IDLE;
        endcase
      end
      ST_SET_A: begin
        cmd.link_wr_a = 1'b1;
        state_nxt     = ST_SET_B;
      end
      ST_SET_B: begin
        cmd.link_wr_b = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_REC_CLR: begin
        cmd.rec_clr = 1'b1;
        s_nxt       = '0;
        k_nxt       = '0;
        state_nxt   = (n == '0) ? ST_REC_OUT : ST_SEED;
      end
      ST_SEED: begin
        cmd.seed_rd   = 1'b1;
        cmd.src_start = (k_r == '0);
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = ST_SEED_T;
        end else begin
          k_nxt = k_r + NW'(1);
        end
      end
      ST_SEED_T: begin
        it_nxt    = NW'(1);
        k_nxt     = '0;
        state_nxt = (n == CW'(1)) ? ST_WB : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = ST_PICK;
        end else begin
          k_nxt = k_r + NW'(1);
        end
      end
      ST_PICK: begin
        k_nxt = '0;
        if (sts.best_ok) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_RELAX;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_RELAX: begin
        cmd.relax_rd = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = ST_RELAX_T;
        end else begin
          k_nxt = k_r + NW'(1);
        end
      end
      ST_RELAX_T: begin
        if (it_last) begin
          state_nxt = ST_WB;
        end else begin
          it_nxt    = it_r + NW'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        if (k_last) begin
          k_nxt = '0;
          if (s_last) begin
            state_nxt = ST_REC_OUT;
          end else begin
            s_nxt     = s_r + NW'(1);
            state_nxt = ST_SEED;
          end
        end else begin
          k_nxt = k_r + NW'(1);
        end
      end
      ST_REC_OUT: begin
        if (sts.out_free) begin
          cmd.rec_emit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_Q_CHECK: begin
        cmd.q_start = 1'b1;
        state_nxt   = ST_Q_RD;
      end
      ST_Q_RD: begin
        cmd.q_rd  = 1'b1;
        state_nxt = ST_Q_EMIT;
      end
      ST_Q_EMIT: begin
        if (sts.out_free) begin
          if (sts.q_one) begin
            cmd.q_one = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.q_emit = 1'b1;
            state_nxt  = sts.q_last ? ST_IDLE : ST_Q_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      s_r     <= '0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      s_r     <= s_nxt;
      it_r    <= it_nxt;
    end
  end

  assign k = k_r;
  assign s = s_r;

endmodule

FILE: design/lsre_dp.sv
// ----------------------------------------------------------------------------
// lsre_dp
// Datapath: link and route memories, working row of one source, result register.
// ----------------------------------------------------------------------------
module lsre_dp #(
  parameter int MAX_NODES = lsre_pkg::MAX_NODES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lsre_pkg::cmd_t                       cmd,
  input  logic [$clog2(MAX_NODES)-1:0]         k,
  input  logic [$clog2(MAX_NODES)-1:0]         s,
  output lsre_pkg::sts_t                       sts,
  output logic [$clog2(MAX_NODES+1)-1:0]       n,
  input  logic                                 cfg_we,
  input  logic [lsre_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [lsre_pkg::MODE_W-1:0]          in_mode,
  input  logic [lsre_pkg::NODE_W-1:0]          in_node_a,
  input  logic [lsre_pkg::NODE_W-1:0]          in_node_b,
  input  logic [lsre_pkg::LINK_W-1:0]          in_link_cost,
  input  logic                                 in_link_down,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_kind,
  output logic                                 out_reachable,
  output logic [lsre_pkg::COST_W-1:0]          out_path_cost,
  output logic                                 out_has_hop,
  output logic [lsre_pkg::NODE_W-1:0]          out_hop_node,
  output logic                                 out_last
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int LD     = 1 << (2 * NW);
  localparam int COST_W = lsre_pkg::COST_W;
  localparam int LINK_W = lsre_pkg::LINK_W;
  localparam int RW     = 1 + COST_W + NW;
  localparam int HOP_W  = lsre_pkg::HOP_W;

  // configuration and latched item
  logic [lsre_pkg::CFG_W-1:0]  cfg_r;
  lsre_pkg::mode_t             mode_r;
  logic [lsre_pkg::NODE_W-1:0] a_r, b_r;
  logic [LINK_W-1:0]           lc_r;
  logic                        down_r;
  logic [NW-1:0]               a_i, b_i;
  logic                        a_in, b_in;

  // link and route state
  logic [LD-1:0]     lvalid_r;
  logic              lv_r;
  logic [CW-1:0]     nrec_r;
  logic              a_rec, b_rec, q_hit;
  logic [LINK_W-1:0] lrd;
  logic [RW-1:0]     rrd;

  // working row of the source being searched
  logic [COST_W-1:0] c_r [MAX_NODES];
  logic [NW-1:0]     h_r [MAX_NODES];
  logic [MAX_NODES-1:0] r_r;
  logic [MAX_NODES-1:0] done_r;

  logic          seed_d_r, relax_d_r;
  logic [NW-1:0] kd_r;
  logic [NW-1:0] ri;
  logic [COST_W-1:0] rc;
  logic          rr;
  logic [NW-1:0] rh;

  logic              best_v_r, best_r_r;
  logic [COST_W-1:0] best_c_r;
  logic [NW-1:0]     best_h_r, best_i_r;
  logic [NW-1:0]     p_r, ph_r;
  logic [COST_W-1:0] pc_r;

  logic              row_we;
  logic [COST_W-1:0] row_c;
  logic              row_r;
  logic [NW-1:0]     row_h;
  logic              lv_d;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] nd;
  logic              first, take;

  // query walk
  logic [NW-1:0]     cur_r;
  logic [HOP_W-1:0]  hop_cnt_r;
  logic [COST_W-1:0] cost_q_r;
  logic [COST_W-1:0] q_cost;
  logic [NW-1:0]     q_nh;
  logic              q_last;

  // result register
  logic              out_valid_r;
  logic              kind_r, reach_r, has_hop_r, last_r;
  logic [COST_W-1:0] cost_r;
  logic [lsre_pkg::NODE_W-1:0] hop_r;
  logic              push, out_free;

  assign n = (int'(cfg_r) > MAX_NODES) ? CW'(MAX_NODES) : CW'(cfg_r);

  assign a_i  = NW'(a_r);
  assign b_i  = NW'(b_r);
  assign a_in = int'(a_r) < int'(n);
  assign b_in = int'(b_r) < int'(n);

  // tables outside the last recomputed node range read as reset
  assign a_rec = int'(a_r) < int'(nrec_r);
  assign b_rec = int'(b_r) < int'(nrec_r);

  // link memory: cost of each ordered pair
  lsre_ram #(.WIDTH(LINK_W), .DEPTH(LD)) u_link_ram (
    .clk   (clk),
    .we    (cmd.link_wr_a | cmd.link_wr_b),
    .waddr (cmd.link_wr_a ? {a_i, b_i} : {b_i, a_i}),
    .wdata (lc_r),
    .re    (cmd.seed_rd | cmd.relax_rd),
    .raddr (cmd.seed_rd ? {s, k} : {p_r, k}),
    .rdata (lrd)
  );

  // route memory: reached flag, cost and first hop per source and destination
  lsre_ram #(.WIDTH(RW), .DEPTH(LD)) u_route_ram (
    .clk   (clk),
    .we    (cmd.wb),
    .waddr ({s, k}),
    .wdata ({rr, rc, rh}),
    .re    (cmd.q_rd),
    .raddr ({cur_r, b_i}),
    .rdata (rrd)
  );

  // working row read port
  assign ri = (cmd.scan | cmd.wb) ? k : kd_r;
  assign rc = c_r[ri];
  assign rr = r_r[ri];
  assign rh = h_r[ri];

  // seeding and relaxation on the delayed index
  assign lv_d = lv_r;
  assign sum  = {1'b0, pc_r} + (COST_W + 1)'(lrd);
  assign nd   = sum[COST_W] ? lsre_pkg::COST_MAX : sum[COST_W-1:0];

  always_comb begin
    row_we = 1'b0;
    row_c  = '0;
    row_r  = 1'b0;
    row_h  = '0;
    if (seed_d_r) begin
      row_we = 1'b1;
      if (kd_r == s) begin
        row_r = 1'b1;
        row_h = s;
      end else if (lv_d) begin
        row_c = COST_W'(lrd);
        row_r = 1'b1;
        row_h = kd_r;
      end
    end else if (relax_d_r) begin
      if (!done_r[kd_r] && lv_d && (!rr || nd < rc)) begin
        row_we = 1'b1;
        row_c  = nd;
        row_r  = 1'b1;
        row_h  = ph_r;
      end
    end
  end

  // lowest-index minimum search
  assign first = (k == '0);
  assign take  = !done_r[k] &&
                 (first || !best_v_r || (rr && (!best_r_r || rc < best_c_r)));

  // query hop
  assign q_hit  = (a_r != b_r) && a_rec && b_rec && rrd[RW-1];
  assign q_cost = (hop_cnt_r == '0) ? rrd[RW-2:NW] : cost_q_r;
  assign q_nh   = rrd[NW-1:0];
  assign q_last = !rrd[RW-1] || (hop_cnt_r == HOP_W'(lsre_pkg::HOP_LIMIT - 1)) ||
                  (q_nh == b_i);

  assign push     = cmd.rec_emit | cmd.q_one | cmd.q_emit;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= lsre_pkg::CFG_RESET;
      lvalid_r    <= '0;
      nrec_r      <= '0;
      done_r      <= '0;
      seed_d_r    <= 1'b0;
      relax_d_r   <= 1'b0;
      best_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.link_wr_a) begin
        lvalid_r[{a_i, b_i}] <= !down_r;
      end
      if (cmd.link_wr_b) begin
        lvalid_r[{b_i, a_i}] <= !down_r;
      end
      if (cmd.rec_clr) begin
        nrec_r <= n;
      end
      if (cmd.src_start) begin
        done_r <= MAX_NODES'(1) << s;
      end else if (cmd.commit) begin
        done_r[best_i_r] <= 1'b1;
      end
      seed_d_r  <= cmd.seed_rd;
      relax_d_r <= cmd.relax_rd;
      if (cmd.scan) begin
        if (take) begin
          best_v_r <= 1'b1;
        end else if (first) begin
          best_v_r <= 1'b0;
        end
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r <= lsre_pkg::mode_t'(in_mode);
      a_r    <= in_node_a;
      b_r    <= in_node_b;
      lc_r   <= in_link_cost;
      down_r <= in_link_down;
    end
    if (cmd.seed_rd | cmd.relax_rd) begin
      lv_r <= lvalid_r[cmd.seed_rd ? {s, k} : {p_r, k}];
    end
    kd_r <= k;
    if (row_we) begin
      c_r[kd_r] <= row_c;
      r_r[kd_r] <= row_r;
      h_r[kd_r] <= row_h;
    end
    if (cmd.scan && take) begin
      best_i_r <= k;
      best_r_r <= rr;
      best_c_r <= rc;
      best_h_r <= rh;
    end
    if (cmd.commit) begin
      p_r  <= best_i_r;
      pc_r <= best_c_r;
      ph_r <= best_h_r;
    end
    if (cmd.q_start) begin
      cur_r     <= a_i;
      hop_cnt_r <= '0;
    end else if (cmd.q_emit) begin
      cur_r     <= q_nh;
      hop_cnt_r <= hop_cnt_r + HOP_W'(1);
      cost_q_r  <= q_cost;
    end
    if (push) begin
      kind_r    <= !cmd.rec_emit;
      last_r    <= cmd.q_emit ? q_last : 1'b1;
      has_hop_r <= cmd.q_emit;
      hop_r     <= cmd.q_emit ? lsre_pkg::NODE_W'(cur_r) : '0;
      if (cmd.q_emit) begin
        reach_r <= 1'b1;
        cost_r  <= q_cost;
      end else if (cmd.q_one) begin
        reach_r <= a_in && b_in && (a_r == b_r);
        cost_r  <= '0;
      end else begin
        reach_r <= 1'b0;
        cost_r  <= '0;
      end
    end
  end

  assign sts.mode     = mode_r;
  assign sts.set_ok   = (a_r != b_r) && a_in && b_in;
  assign sts.q_one    = (hop_cnt_r == '0) && (!a_in || !b_in || !q_hit);
  assign sts.q_last   = q_last;
  assign sts.best_ok  = best_v_r && best_r_r;
  assign sts.out_free = out_free;

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_reachable = reach_r;
  assign out_path_cost = cost_r;
  assign out_has_hop   = has_hop_r;
  assign out_hop_node  = hop_r;
  assign out_last      = last_r;

`ifndef ASSERT_OFF
  a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> best_v_r && best_r_r && !done_r[best_i_r])
    else $error("settled node picked twice or unreached");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result register overwritten");

  a_src_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> done_r[s])
    else $error("source not settled during scan");

  a_walk_reach: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_emit |-> a_in && b_in && (a_r != b_r))
    else $error("hop walk on unreached pair");
`endif

endmodule

FILE: design/link_state_route_engine.sv
// ----------------------------------------------------------------------------
// link_state_route_engine
// Link-cost matrix with per-source shortest-path tables and route queries.
//
//   channel | dir | handshake        | payload
//   in_ch   | in  | valid / ready    | mode, node_a, node_b, link_cost, link_down
//   out_ch  | out | valid / ready    | kind, reachable, path_cost, has_hop, hop_node, last
//   cfg     | in  | cfg_we           | cfg_wdata (node_count)
//
// set link: writes both directions, no result. query: one result per hop, or a single one when there is no hop.
// recompute: the link memory has one read port; each settle step scans n nodes then
// relaxes n links.
// one item at a time; a full result register stalls the sequencer only.
// synchronous active-low reset; link and route tables are empty after reset.
// ----------------------------------------------------------------------------
module link_state_route_engine #(
  parameter int MAX_NODES = lsre_pkg::MAX_NODES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lsre_in_if.sink                      in_ch,
  lsre_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [lsre_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  lsre_pkg::cmd_t cmd;
  lsre_pkg::sts_t sts;
  logic [NW-1:0]  k, s;
  logic [CW-1:0]  n;

  lsre_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .n        (n),
    .cmd      (cmd),
    .k        (k),
    .s        (s)
  );

  lsre_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .k             (k),
    .s             (s),
    .sts           (sts),
    .n             (n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_mode       (in_ch.mode),
    .in_node_a     (in_ch.node_a),
    .in_node_b     (in_ch.node_b),
    .in_link_cost  (in_ch.link_cost),
    .in_link_down  (in_ch.link_down),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_kind      (out_ch.kind),
    .out_reachable (out_ch.reachable),
    .out_path_cost (out_ch.path_cost),
    .out_has_hop   (out_ch.has_hop),
    .out_hop_node  (out_ch.hop_node),
    .out_last      (out_ch.last)
  );

endmodule
